[design/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the circular deque unit
// Action and status codes, and the per-cell control group.
// ----------------------------------------------------------------------------
package cdq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_PEEK_FRONT = 3'd2,
    ACT_PEEK_BACK  = 3'd3,
    ACT_POP_FRONT  = 3'd4,
    ACT_POP_BACK   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic push_back;
    logic pop_back;
  } cell_ctl_t;

endpackage

[design/cdq_cell.sv]
// ----------------------------------------------------------------------------
// cdq_cell: one deque slot
// Holds one element and its occupied bit; shifts with its neighbors and
// flags itself as the tail when it is the last occupied slot.
// ----------------------------------------------------------------------------
module cdq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdq_pkg::cell_ctl_t    ctl_i,
  input  logic [DATA_WIDTH-1:0] new_data_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  right_valid_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] leaf_o
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  valid_r, valid_nxt;
  logic                  is_tail;

  assign is_tail = valid_r && !right_valid_i;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl_i.shift_right) begin
      data_nxt  = left_data_i;
      valid_nxt = left_valid_i;
    end else if (ctl_i.shift_left) begin
      data_nxt  = right_data_i;
      valid_nxt = right_valid_i;
    end else if (ctl_i.push_back && !valid_r && left_valid_i) begin
      data_nxt  = new_data_i;
      valid_nxt = 1'b1;
    end else if (ctl_i.pop_back && is_tail) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;
  assign leaf_o  = is_tail ? data_r : '0;

endmodule

[design/cdq_or_tree.sv]
// ----------------------------------------------------------------------------
// cdq_or_tree: registered OR-reduction tree
// Merges the tail leaves of all cells into one word, each level registered.
// ----------------------------------------------------------------------------
module cdq_or_tree #(
  parameter int DATA_WIDTH = 32,
  parameter int LEAVES     = 128
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] leaf_i [LEAVES],
  output logic [DATA_WIDTH-1:0] root_o
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int PAD    = 2 ** LEVELS;

  logic [DATA_WIDTH-1:0] lf     [PAD];
  logic [DATA_WIDTH-1:0] node_r [1:PAD-1];

  for (genvar j = 0; j < PAD; j++) begin : g_pad
    if (j < LEAVES) begin : g_real
      assign lf[j] = leaf_i[j];
    end else begin : g_zero
      assign lf[j] = '0;
    end
  end

  for (genvar n = 1; n < PAD; n++) begin : g_node
    if (2 * n >= PAD) begin : g_bottom
      always_ff @(posedge clk) begin
        node_r[n] <= lf[2*n-PAD] | lf[2*n+1-PAD];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_r[n] <= node_r[2*n] | node_r[2*n+1];
      end
    end
  end

  assign root_o = node_r[1];

endmodule

[design/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue built as a row of shifting cells
// Front actions and pushes go through accept, execute and result in turn.
// Peek back and pop back first wait in S_WAIT for the registered OR tree
// that finds the tail cell, then execute; no new action is taken while busy.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset clears the occupancy and all occupied bits; element data is not reset.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         in_action,
  input  logic [DATA_WIDTH-1:0]              in_data_in,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [DATA_WIDTH-1:0]              out_data_out,
  output logic [$clog2(CAPACITY+1)-1:0]      out_occupancy
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = $clog2(CAPACITY);
  localparam int WCW    = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [WCW-1:0]        cnt_r, cnt_nxt;
  cdq_pkg::action_t      act_r, act_nxt;
  logic [DATA_WIDTH-1:0] din_r, din_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  cdq_pkg::status_t      status_r, status_nxt;
  logic [DATA_WIDTH-1:0] dout_r, dout_nxt;

  cdq_pkg::cell_ctl_t    ctl_c, cell_ctl;
  logic                  accept, back_rd, full, empty;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_leaf [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid;
  logic [DATA_WIDTH-1:0] tail_data;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign back_rd = (in_action == cdq_pkg::ACT_PEEK_BACK) ||
                   (in_action == cdq_pkg::ACT_POP_BACK);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    din_nxt   = din_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt = cdq_pkg::action_t'(in_action);
          din_nxt = in_data_in;
          if (back_rd) begin
            state_nxt = S_WAIT;
            cnt_nxt   = WCW'(LEVELS - 1);
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_WAIT: begin
        if (cnt_r == '0) begin
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_c      = '0;
    status_nxt = cdq_pkg::STAT_DONE;
    dout_nxt   = '0;
    count_nxt  = count_r;
    case (act_r)
      cdq_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          status_nxt = cdq_pkg::STAT_FULL;
        end else begin
          ctl_c.shift_right = 1'b1;
          count_nxt         = count_r + 1'b1;
        end
      end
      cdq_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status_nxt = cdq_pkg::STAT_FULL;
        end else begin
          ctl_c.push_back = 1'b1;
          count_nxt       = count_r + 1'b1;
        end
      end
      cdq_pkg::ACT_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = cdq_pkg::STAT_EMPTY;
        end else begin
          dout_nxt = cell_data[0];
        end
      end
      cdq_pkg::ACT_PEEK_BACK: begin
        if (empty) begin
          status_nxt = cdq_pkg::STAT_EMPTY;
        end else begin
          dout_nxt = tail_data;
        end
      end
      cdq_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          status_nxt = cdq_pkg::STAT_EMPTY;
        end else begin
          dout_nxt         = cell_data[0];
          ctl_c.shift_left = 1'b1;
          count_nxt        = count_r - 1'b1;
        end
      end
      cdq_pkg::ACT_POP_BACK: begin
        if (empty) begin
          status_nxt = cdq_pkg::STAT_EMPTY;
        end else begin
          dout_nxt       = tail_data;
          ctl_c.pop_back = 1'b1;
          count_nxt      = count_r - 1'b1;
        end
      end
      default: begin
        ctl_c = '0;
      end
    endcase
  end

  assign cell_ctl      = (state_r == S_EXEC) ? ctl_c : '0;
  assign out_valid_nxt = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_EXEC) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    din_r <= din_nxt;
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      dout_r   <= dout_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;
    logic                  left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = din_r;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl_i         (cell_ctl),
      .new_data_i    (din_r),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .leaf_o        (cell_leaf[i])
    );
  end

  cdq_or_tree #(
    .DATA_WIDTH (DATA_WIDTH),
    .LEAVES     (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaf_i (cell_leaf),
    .root_o (tail_data)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data_out  = dout_r;
  assign out_occupancy = count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_valid_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("occupied cells disagree with occupancy");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid_r)
    else $error("missing result strobe");

  a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result strobe without execution");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == cdq_pkg::STAT_FULL)) |-> full)
    else $error("full status with free space");

endmodule

[tb/tb_circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// tb_circular_deque_unit: self-checking bench for the circular deque unit
// Drives push, peek and pop actions at both ends through the start/busy
// handshake and keeps a shadow deque that predicts status, data and
// occupancy for every item. A directed part covers empty access, both
// ends, wrap of the head and the unused action codes. Random traffic then
// swings the store between full and empty so that rejected pushes and
// empty reads occur many times.
// ----------------------------------------------------------------------------
module tb_circular_deque_unit;

  localparam int CAP        = 128;
  localparam int DW         = 32;
  localparam int OCC_W      = $clog2(CAP + 1);
  localparam int STALL_MAX  = 2000;
  localparam int PRINT_MAX  = 100;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  typedef struct {
    cdq_pkg::status_t status;
    logic [DW-1:0]    data;
    logic [OCC_W-1:0] occupancy;
  } deque_reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       in_action = cdq_pkg::ACT_PUSH_FRONT;
  logic [DW-1:0]    in_data_in = '0;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [DW-1:0]    out_data_out;
  logic [OCC_W-1:0] out_occupancy;

  logic [DW-1:0]    shadow_store [CAP];
  int               shadow_head = 0;
  int               shadow_count = 0;
  deque_reply_t     reply_queue [$];
  int               mismatches = 0;
  int               stall_cycles = 0;
  bit               idle_enabled = 1'b1;

  circular_deque_unit #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(DW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_occupancy(out_occupancy)
  );

  always #5 clk = ~clk;

  function automatic void model_action(input logic [2:0] act, input logic [DW-1:0] din);
    deque_reply_t r;
    int slot;
    r.status = cdq_pkg::STAT_DONE;
    r.data   = '0;
    case (act)
      cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_BACK: begin
        if (shadow_count >= CAP) begin
          r.status = cdq_pkg::STAT_FULL;
        end else if (act == cdq_pkg::ACT_PUSH_FRONT) begin
          shadow_head = (shadow_head == 0) ? CAP - 1 : shadow_head - 1;
          shadow_store[shadow_head] = din;
          shadow_count++;
        end else begin
          shadow_store[(shadow_head + shadow_count) % CAP] = din;
          shadow_count++;
        end
      end
      cdq_pkg::ACT_PEEK_FRONT, cdq_pkg::ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = cdq_pkg::STAT_EMPTY;
        end else begin
          r.data = shadow_store[shadow_head];
          if (act == cdq_pkg::ACT_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % CAP;
            shadow_count--;
          end
        end
      end
      cdq_pkg::ACT_PEEK_BACK, cdq_pkg::ACT_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = cdq_pkg::STAT_EMPTY;
        end else begin
          slot = (shadow_head + shadow_count - 1) % CAP;
          r.data = shadow_store[slot];
          if (act == cdq_pkg::ACT_POP_BACK) shadow_count--;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(shadow_count);
    reply_queue.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    if (mismatches < PRINT_MAX)
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    deque_reply_t want;
    if (rst_n && out_valid) begin
      if (reply_queue.size() == 0) begin
        report_mismatch("result with no item waiting", out_data_out, '0);
      end else begin
        want = reply_queue.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", DW'(out_status), DW'(want.status));
        if (out_data_out !== want.data)
          report_mismatch("data_out", out_data_out, want.data);
        if (out_occupancy !== want.occupancy)
          report_mismatch("occupancy", DW'(out_occupancy), DW'(want.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("circular_deque_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue_action(input logic [2:0] act, input logic [DW-1:0] din);
    int gap;
    if (idle_enabled && $urandom_range(99) < 15) begin
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_action  <= act;
    in_data_in <= din;
    do @(posedge clk); while (busy);
    model_action(act, din);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_access();
    issue_action(cdq_pkg::ACT_PEEK_FRONT, '1);
    issue_action(cdq_pkg::ACT_PEEK_BACK, '0);
    issue_action(cdq_pkg::ACT_POP_FRONT, '1);
    issue_action(cdq_pkg::ACT_POP_BACK, '0);
    drain_replies();
  endtask

  task automatic test_both_ends();
    issue_action(cdq_pkg::ACT_PUSH_FRONT, '0);
    issue_action(cdq_pkg::ACT_PUSH_BACK, '1);
    issue_action(cdq_pkg::ACT_PUSH_FRONT, 32'hAAAA_AAAA);
    issue_action(cdq_pkg::ACT_PUSH_BACK, 32'h5555_5555);
    issue_action(cdq_pkg::ACT_PEEK_FRONT, '0);
    issue_action(cdq_pkg::ACT_PEEK_BACK, '0);
    issue_action(cdq_pkg::ACT_POP_BACK, '0);
    issue_action(cdq_pkg::ACT_POP_FRONT, '0);
    issue_action(cdq_pkg::ACT_POP_FRONT, '0);
    issue_action(cdq_pkg::ACT_POP_BACK, '0);
    issue_action(cdq_pkg::ACT_POP_FRONT, '0);
    drain_replies();
  endtask

  task automatic test_spare_codes();
    issue_action(ACT_SPARE_6, '1);
    issue_action(cdq_pkg::ACT_PUSH_BACK, 32'h8000_0001);
    issue_action(ACT_SPARE_7, '1);
    issue_action(cdq_pkg::ACT_POP_FRONT, '0);
    drain_replies();
  endtask

  task automatic test_random_traffic(input int item_total);
    traffic_mode_t mode;
    int mixed_left;
    int push_pct;
    int roll;
    logic [2:0] act;
    logic [DW-1:0] din;
    mode = MODE_FILL;
    mixed_left = 0;
    for (int n = 0; n < item_total; n++) begin
      idle_enabled = !(n >= item_total / 3 && n < item_total / 3 + 400);
      if (n == item_total / 2) drain_replies();
      case (mode)
        MODE_FILL: if (shadow_count == CAP && $urandom_range(3) == 0) mode = MODE_DRAIN;
        MODE_DRAIN: begin
          if (shadow_count == 0 && $urandom_range(3) == 0) begin
            mode = MODE_MIXED;
            mixed_left = $urandom_range(40, 160);
          end
        end
        default: begin
          if (mixed_left == 0) mode = MODE_FILL;
          else mixed_left--;
        end
      endcase
      push_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 15 : 38;
      roll = $urandom_range(99);
      if (roll < 2) begin
        act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
      end else if (roll < 2 + push_pct) begin
        act = $urandom_range(1) ? cdq_pkg::ACT_PUSH_FRONT : cdq_pkg::ACT_PUSH_BACK;
      end else if ($urandom_range(99) < 70) begin
        act = $urandom_range(1) ? cdq_pkg::ACT_POP_FRONT : cdq_pkg::ACT_POP_BACK;
      end else begin
        act = $urandom_range(1) ? cdq_pkg::ACT_PEEK_FRONT : cdq_pkg::ACT_PEEK_BACK;
      end
      roll = $urandom_range(9);
      din = (roll == 0) ? '0 : (roll == 1) ? '1 : DW'($urandom);
      issue_action(act, din);
    end
    idle_enabled = 1'b1;
    drain_replies();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_access();
    test_both_ends();
    test_spare_codes();
    test_random_traffic(1950);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && reply_queue.size() == 0) begin
      $display("circular_deque_unit: match");
    end else begin
      $display("circular_deque_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
design/cdq_pkg.sv
design/cdq_cell.sv
design/cdq_or_tree.sv
design/circular_deque_unit.sv
tb/tb_circular_deque_unit.sv
